### rtl/core/plti_pkg.sv
package plti_pkg;

  localparam int unsigned EW = 32;
  localparam int unsigned LW = 32;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CW = $clog2(DIV_STEPS);
  localparam int unsigned QW = 34;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SECOND = 2'd1;

  localparam logic [CFG_W-1:0] LAST_FIRST_RST = 7'd126;
  localparam logic [CFG_W-1:0] LAST_SECOND_RST = 7'd80;

  typedef enum logic [1:0] {
    ADDR_WR,
    ADDR_L,
    ADDR_M,
    ADDR_U
  } addr_sel_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ZERO,
    OUT_TRIV,
    OUT_FIN
  } emit_t;

  typedef struct packed {
    logic      q_load;
    logic      wr;
    addr_sel_t addr_sel;
    logic      cap_el;
    logic      cap_em;
    logic      dec;
    logic      cap_lo;
    logic      cap_hi;
    logic      calc;
    logic      mul;
    logic      div_step;
    emit_t     emit;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic brk;
    logic triv;
    logic div_last;
  } status_t;

endpackage

### rtl/core/plti_ram.sv
module plti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/plti_ctrl.sv
module plti_ctrl
  import plti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       req_type,
  input  logic [1:0] table_select,
  input  status_t    st,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_CHK  = 11'b000_0000_0010,
    S_RL   = 11'b000_0000_0100,
    S_RM   = 11'b000_0000_1000,
    S_RU   = 11'b000_0001_0000,
    S_DEC  = 11'b000_0010_0000,
    S_FL   = 11'b000_0100_0000,
    S_FU   = 11'b000_1000_0000,
    S_FW   = 11'b001_0000_0000,
    S_CALC = 11'b010_0000_0000,
    S_DIV  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   fin, fin_next;
  logic   known;

  assign busy = (state != S_IDLE) || fin;
  assign known = (table_select == SEL_FIRST) || (table_select == SEL_SECOND);

  always_comb begin
    state_next = state;
    fin_next = 1'b0;
    cmd = '0;
    cmd.addr_sel = ADDR_WR;
    cmd.emit = OUT_NONE;
    unique case (state)
      S_IDLE: begin
        if (fin) begin
          cmd.emit = OUT_FIN;
        end else if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.wr = 1'b1;
          end else if (known) begin
            cmd.q_load = 1'b1;
            state_next = S_CHK;
          end else begin
            cmd.emit = OUT_ZERO;
          end
        end
      end
      S_CHK: state_next = (st.lt && !st.brk) ? S_RL : S_FL;
      S_RL: begin
        cmd.addr_sel = ADDR_L;
        state_next = S_RM;
      end
      S_RM: begin
        cmd.addr_sel = ADDR_M;
        cmd.cap_el = 1'b1;
        state_next = S_RU;
      end
      S_RU: begin
        cmd.addr_sel = ADDR_U;
        cmd.cap_em = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        state_next = S_CHK;
      end
      S_FL: begin
        cmd.addr_sel = ADDR_L;
        state_next = S_FU;
      end
      S_FU: begin
        cmd.addr_sel = ADDR_U;
        cmd.cap_lo = 1'b1;
        state_next = S_FW;
      end
      S_FW: begin
        cmd.cap_hi = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        if (st.triv) begin
          cmd.emit = OUT_TRIV;
          state_next = S_IDLE;
        end else begin
          cmd.calc = 1'b1;
          cmd.mul = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          fin_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
    end
  end

  // division always runs its full length before the result step
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && st.div_last) |=> (fin && state == S_IDLE))
    else $error("division end not followed by result step");

  assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (state == S_IDLE && !fin))
    else $error("table write outside idle");

endmodule

### rtl/core/plti_dp.sv
module plti_dp
  import plti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic [1:0]           table_select,
  input  logic [6:0]           entry_index,
  input  logic [EW-1:0]        energy,
  input  logic signed [LW-1:0] limit_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 done,
  output logic signed [LW-1:0] limit_out,
  output logic                 saturated
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned AW = IW + 1;
  localparam int unsigned MEM_DEPTH = 2 ** AW;

  logic [CFG_W-1:0] last_first, last_second, last_raw;
  logic [IW-1:0]    last_c, l, u, m;
  logic [IW:0]      lu_sum;
  logic             base, brk;
  logic [EW-1:0]    qe, el, em, eu, erd;
  logic [LW-1:0]    ll, lu, lrd;
  logic [AW-1:0]    addr;
  logic             wr_ok;
  logic [31:0]      a_abs, b_abs, d_abs;
  logic             neg;
  logic [63:0]      prod;
  logic [31:0]      rem;
  logic [32:0]      rem_sh;
  logic             q_bit;
  logic [DIV_CW-1:0] cnt;
  logic signed [32:0] dl, dx, de;
  logic signed [35:0] sum;
  logic             big;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      last_first <= LAST_FIRST_RST;
      last_second <= LAST_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_LAST_FIRST) last_first <= cfg_wdata;
      if (cfg_idx == CFG_LAST_SECOND) last_second <= cfg_wdata;
    end
  end

  assign last_raw = (table_select == SEL_FIRST) ? last_first : last_second;
  always_comb begin
    if (32'(last_raw) >= 32'(TABLE_DEPTH)) last_c = IW'(TABLE_DEPTH - 1);
    else last_c = IW'(last_raw);
  end

  assign lu_sum = {1'b0, l} + {1'b0, u};
  assign m = lu_sum[IW:1];

  assign wr_ok = cmd.wr && ((table_select == SEL_FIRST) || (table_select == SEL_SECOND))
                 && (32'(entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_WR: addr = {table_select[0], IW'(entry_index)};
      ADDR_L:  addr = {base, l};
      ADDR_M:  addr = {base, m};
      ADDR_U:  addr = {base, u};
      default: addr = {base, l};
    endcase
  end

  plti_ram #(.WIDTH(EW), .DEPTH(MEM_DEPTH)) u_energy_ram (
    .clk(clk), .we(wr_ok), .addr(addr), .wdata(energy), .rdata(erd)
  );

  plti_ram #(.WIDTH(LW), .DEPTH(MEM_DEPTH)) u_limit_ram (
    .clk(clk), .we(wr_ok), .addr(addr), .wdata(limit_in), .rdata(lrd)
  );

  // search bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      l <= '0;
      u <= '0;
      brk <= 1'b0;
    end else if (cmd.q_load) begin
      l <= '0;
      u <= last_c;
      brk <= 1'b0;
    end else if (cmd.dec) begin
      if (qe == el) begin
        u <= l;
      end else if (qe == em) begin
        l <= m;
        u <= m;
      end else if (qe == erd) begin
        l <= u;
      end else if (qe < em) begin
        u <= m;
      end else if (l == m) begin
        brk <= 1'b1;
      end else begin
        l <= m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      base <= table_select[0];
      qe <= energy;
    end
    if (cmd.cap_el || cmd.cap_lo) el <= erd;
    if (cmd.cap_em) em <= erd;
    if (cmd.cap_lo) ll <= lrd;
    if (cmd.cap_hi) begin
      eu <= erd;
      lu <= lrd;
    end
  end

  // segment differences
  assign dl = 33'(signed'(lu)) - 33'(signed'(ll));
  assign dx = signed'({1'b0, qe}) - signed'({1'b0, el});
  assign de = signed'({1'b0, eu}) - signed'({1'b0, el});

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      neg <= dl[32] ^ dx[32] ^ de[32];
      d_abs <= de[32] ? 32'(-de) : de[31:0];
    end
  end

  assign a_abs = dl[32] ? 32'(-dl) : dl[31:0];
  assign b_abs = dx[32] ? 32'(-dx) : dx[31:0];

  // restoring division, one quotient bit per step; the dividend shifts out
  // of prod as the quotient shifts in
  assign rem_sh = {rem, prod[63]};
  assign q_bit = rem_sh >= {1'b0, d_abs};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 64'(a_abs) * 64'(b_abs);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? 32'(rem_sh - {1'b0, d_abs}) : rem_sh[31:0];
      prod <= {prod[62:0], q_bit};
      cnt <= cnt + 1'b1;
    end
  end

  assign big = |prod[63:QW];
  assign sum = neg ? 36'(signed'(ll)) - signed'({2'b0, prod[QW-1:0]})
                   : 36'(signed'(ll)) + signed'({2'b0, prod[QW-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.emit != OUT_NONE);
    end
    unique case (cmd.emit)
      OUT_ZERO: begin
        limit_out <= '0;
        saturated <= 1'b0;
      end
      OUT_TRIV: begin
        limit_out <= signed'(ll);
        saturated <= 1'b0;
      end
      OUT_FIN: begin
        if (big) begin
          limit_out <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          saturated <= 1'b1;
        end else if (sum > 36'sh0_7fff_ffff) begin
          limit_out <= 32'sh7fff_ffff;
          saturated <= 1'b1;
        end else if (sum < -36'sh0_8000_0000) begin
          limit_out <= 32'sh8000_0000;
          saturated <= 1'b1;
        end else begin
          limit_out <= sum[31:0];
          saturated <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign st.lt = l < u;
  assign st.brk = brk;
  assign st.triv = (l == u) || (eu == el);
  assign st.div_last = (cnt == DIV_CW'(DIV_STEPS - 1));

  assert property (@(posedge clk) disable iff (rst) l <= u)
    else $error("search bounds crossed");

  assert property (@(posedge clk) disable iff (rst) (l <= m) && (m <= u))
    else $error("midpoint outside bounds");

endmodule

### rtl/core/piecewise_linear_table_interp_core.sv
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// request   | start / busy        | req_type table_select entry_index
//           |                     | energy limit_in
// result    | done (1-cycle pulse)| limit_out saturated
// config    | cfg_we              | cfg_idx cfg_wdata
//
// A request is taken at a clock edge with start high and busy low.
// A load request writes the energy and limit entries in that edge; busy stays
// low, no result.
// A query on an unknown table gives its zero result the next cycle.
// A query runs the binary search, each halving made of a bound check, three
// reads of the single energy port and a decide step, then a final bound check,
// a fetch of the bracketing pair, a product step, the bit-serial divide and a
// result step. An exact match or a zero span skips the divide.
// Reset (rst, synchronous) returns the controller to idle and the last-index
// registers to 126 and 80; table contents stay undefined until loaded.
// The receiver cannot stall: done marks the result for exactly one cycle.
module piecewise_linear_table_interp_core
  import plti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [1:0]           table_select,
  input  logic [6:0]           entry_index,
  input  logic [EW-1:0]        energy,
  input  logic signed [LW-1:0] limit_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 done,
  output logic signed [LW-1:0] limit_out,
  output logic                 saturated
);

  cmd_t    cmd;
  status_t st;

  // sequence the search, fetch and divide
  plti_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req_type(req_type),
    .table_select(table_select),
    .st(st),
    .busy(busy),
    .cmd(cmd)
  );

  // tables, search bounds, multiplier, divider and result register
  plti_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .table_select(table_select),
    .entry_index(entry_index),
    .energy(energy),
    .limit_in(limit_in),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .limit_out(limit_out),
    .saturated(saturated)
  );

endmodule

### test/piecewise_linear_table_interp_core_tb.sv
module piecewise_linear_table_interp_core_tb;
  import plti_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 30;

  // Selector values the package leaves unnamed: both mean "no table".
  localparam logic [1:0] SEL_NONE = 2'd2;
  localparam logic [1:0] SEL_BAD = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [LW-1:0] LIM_MAX = 32'sh7fffffff;
  localparam logic signed [LW-1:0] LIM_MIN = 32'sh80000000;
  localparam logic signed [95:0] QUOT_BIG = 96'sd17179869184;

  typedef struct {
    logic                 lim;
    logic [1:0]           sel;
    logic [6:0]           idx;
    logic [EW-1:0]        en;
    logic [LW-1:0]        lim_in;
    bit                   typed;
    logic signed [LW-1:0] x_lim;
    bit                   x_sat;
  } dir_row_t;

  typedef struct {
    logic signed [LW-1:0] lim;
    bit                   sat;
  } limit_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type = REQ_LOAD;
  logic [1:0]           table_select = SEL_FIRST;
  logic [6:0]           entry_index = '0;
  logic [EW-1:0]        energy = '0;
  logic signed [LW-1:0] limit_in = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_LAST_FIRST;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 done;
  logic signed [LW-1:0] limit_out;
  logic                 saturated;

  // Shadow copy of the block: both breakpoint tables and the last-index registers.
  logic [EW-1:0] bp_energy [0:2*DEPTH-1];
  logic [LW-1:0] bp_limit [0:2*DEPTH-1];
  logic [CFG_W-1:0] last_idx [0:1];

  limit_result_t pending_limits [$];
  int unsigned   err_count = 0;
  int unsigned   cyc = 0;
  bit            no_idle = 1'b0;

  piecewise_linear_table_interp_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .table_select(table_select),
    .entry_index(entry_index),
    .energy(energy),
    .limit_in(limit_in),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .limit_out(limit_out),
    .saturated(saturated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: fail and end the run once the cycle counter passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAIL piecewise_linear_table_interp_core");
      $finish;
    end
  end

  // Check each result against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_limits.size() == 0) begin
        $display("%0t: unexpected result limit=%h sat=%b", $time, limit_out, saturated);
        err_count++;
      end else begin
        if (limit_out !== pending_limits[0].lim) begin
          $display("%0t: limit_out expected %h actual %h", $time,
                   pending_limits[0].lim, limit_out);
          err_count++;
        end
        if (saturated !== pending_limits[0].sat) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   pending_limits[0].sat, saturated);
          err_count++;
        end
        void'(pending_limits.pop_front());
      end
    end
  end

  // Search the used range of a table and interpolate, exactly and saturated.
  function automatic limit_result_t interp_limit(input logic [1:0] sel, input logic [EW-1:0] e);
    limit_result_t     res;
    int unsigned       b;
    int unsigned       l;
    int unsigned       u;
    int unsigned       m;
    logic signed [95:0] base;
    logic signed [95:0] dl;
    logic signed [95:0] dx;
    logic signed [95:0] de;
    logic signed [95:0] q;
    res.lim = '0;
    res.sat = 1'b0;
    if (sel != SEL_FIRST && sel != SEL_SECOND) return res;
    b = sel * DEPTH;
    l = 0;
    u = last_idx[sel];
    while (l < u) begin
      m = (l + u) / 2;
      if (e == bp_energy[b+l]) begin
        u = l;
      end else if (e == bp_energy[b+m]) begin
        l = m;
        u = m;
      end else if (e == bp_energy[b+u]) begin
        l = u;
      end else if (e < bp_energy[b+m]) begin
        u = m;
      end else begin
        if (l == m) break;
        l = m;
      end
    end
    base = {{64{bp_limit[b+l][31]}}, bp_limit[b+l]};
    res.lim = base[31:0];
    if (l == u) return res;
    de = {64'b0, bp_energy[b+u]} - {64'b0, bp_energy[b+l]};
    if (de == 0) return res;
    dl = {{64{bp_limit[b+u][31]}}, bp_limit[b+u]} - base;
    dx = {64'b0, e} - {64'b0, bp_energy[b+l]};
    q = (dl * dx) / de;
    if (q >= QUOT_BIG || -q >= QUOT_BIG) begin
      res.sat = 1'b1;
      res.lim = (q < 0) ? LIM_MIN : LIM_MAX;
      return res;
    end
    q = base + q;
    if (q > 96'sd2147483647) begin
      res.sat = 1'b1;
      res.lim = LIM_MAX;
    end else if (q < -96'sd2147483648) begin
      res.sat = 1'b1;
      res.lim = LIM_MIN;
    end else begin
      res.lim = q[31:0];
    end
    return res;
  endfunction

  // Present one request, hold it until taken, then update the shadow state.
  task automatic send_request(input logic rq, input logic [1:0] sl, input logic [6:0] ix,
                              input logic [EW-1:0] en, input logic [LW-1:0] lm,
                              input bit typed, input logic [LW-1:0] x_lim, input bit x_sat);
    int unsigned   gap;
    limit_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    table_select <= sl;
    entry_index <= ix;
    energy <= en;
    limit_in <= lm;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (rq == REQ_LOAD) begin
      if (sl == SEL_FIRST || sl == SEL_SECOND) begin
        bp_energy[sl*DEPTH+ix] = en;
        bp_limit[sl*DEPTH+ix] = lm;
      end
    end else begin
      if (typed) begin
        r.lim = x_lim;
        r.sat = x_sat;
      end else begin
        r = interp_limit(sl, en);
      end
      pending_limits.push_back(r);
    end
  endtask

  // Hold the request side until every result is in and the block is quiet.
  task automatic drain;
    start <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ix, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= ix;
    cfg_wdata <= val;
    @(posedge clk);
    if (ix == CFG_LAST_FIRST || ix == CFG_LAST_SECOND) last_idx[ix] = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reload a window of low entries of one table: rising energies by default,
  // or a small set of repeated values to give unsorted tables and equal
  // neighbors. Entries above the window keep their older contents.
  task automatic load_table(input logic [1:0] t, input bit rough);
    logic [EW-1:0] e;
    logic [LW-1:0] lv;
    int unsigned   step_max;
    int signed     slope;
    int unsigned   lmode;
    int            n_load;
    case ($urandom_range(0, 2))
      0: e = '0;
      1: e = $urandom_range(0, 1 << 20);
      default: e = 32'h8000_0000 + $urandom_range(0, 1 << 16);
    endcase
    step_max = 1 << $urandom_range(4, 23);
    lmode = $urandom_range(0, 3);
    lv = $urandom;
    slope = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    n_load = $urandom_range(8, 24);
    for (int i = 0; i < n_load; i++) begin
      if (rough) e = $urandom_range(0, 7) << 12;
      case (lmode)
        0, 1: lv = lv + slope;
        2: lv = $urandom;
        default: lv = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? LIM_MAX : LIM_MIN)
                                                : $urandom;
      endcase
      send_request(REQ_LOAD, t, i[6:0], e, lv, 1'b0, '0, 1'b0);
      if (!rough) e = e + $urandom_range(1, step_max);
    end
  endtask

  // Directed requests against the tables loaded right after reset.
  dir_row_t dir_rows [] = '{
    '{REQ_QUERY, SEL_NONE, 7'd0, 32'h0, 32'h0, 1'b1, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_BAD, 7'd127, 32'hffffffff, 32'hffffffff, 1'b1, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'h0, 32'h0, 1'b1, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'd20480, 32'h0, 1'b1, 32'sh50000, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'd22528, 32'h0, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'hffffffff, 32'h0, 1'b1, LIM_MAX, 1'b1},
    '{REQ_QUERY, SEL_SECOND, 7'd0, 32'h0, 32'h0, 1'b1, 32'sh0, 1'b0},
    '{REQ_LOAD, SEL_NONE, 7'd0, 32'hffffffff, 32'h80000000, 1'b0, 32'sh0, 1'b0},
    '{REQ_LOAD, SEL_BAD, 7'd5, 32'h0, 32'h7fffffff, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'd20480, 32'h0, 1'b1, 32'sh50000, 1'b0},
    '{REQ_LOAD, SEL_FIRST, 7'd127, 32'hffffffff, 32'h7fffffff, 1'b0, 32'sh0, 1'b0},
    '{REQ_LOAD, SEL_FIRST, 7'd126, 32'hffffff00, 32'h80000000, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'hffffffff, 32'h0, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'hffffff00, 32'h0, 1'b1, LIM_MIN, 1'b0},
    '{REQ_QUERY, SEL_SECOND, 7'd0, 32'hffffffff, 32'h0, 1'b1, LIM_MAX, 1'b1},
    '{REQ_LOAD, SEL_SECOND, 7'd80, 32'd1536, 32'h80000000, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_SECOND, 7'd0, 32'hffffffff, 32'h0, 1'b1, LIM_MIN, 1'b1},
    '{REQ_QUERY, SEL_SECOND, 7'd0, 32'd1536, 32'h0, 1'b1, LIM_MIN, 1'b0},
    '{REQ_QUERY, SEL_SECOND, 7'd0, 32'd1544, 32'h0, 1'b0, 32'sh0, 1'b0},
    '{REQ_LOAD, SEL_FIRST, 7'd3, 32'd12288, 32'h7fffffff, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'd14336, 32'h0, 1'b0, 32'sh0, 1'b0},
    '{REQ_QUERY, SEL_FIRST, 7'd0, 32'd10240, 32'h0, 1'b0, 32'sh0, 1'b0}
  };

  // Last-index pairs per phase; the first pair matches the reset values.
  logic [CFG_W-1:0] phase_last [0:PHASES-1][0:1] = '{
    '{7'd126, 7'd80}, '{7'd127, 7'd1}, '{7'd1, 7'd127}, '{7'd0, 7'd0},
    '{7'd127, 7'd127}, '{7'd64, 7'd3}, '{7'd5, 7'd100}, '{7'd33, 7'd17}
  };

  initial begin
    logic [1:0]    sl;
    logic [EW-1:0] en;
    int unsigned   k;
    int unsigned   pick;
    last_idx[0] = LAST_FIRST_RST;
    last_idx[1] = LAST_SECOND_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every entry of both tables so no query ever touches an unwritten one:
    // the first table rises by 1.0 eV per entry with slope 1.0, the second by
    // 16 LSB per entry with a steep slope so that extrapolation overflows.
    for (int i = 0; i < DEPTH; i++)
      send_request(REQ_LOAD, SEL_FIRST, i[6:0], i * 4096, i << 16, 1'b0, '0, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      send_request(REQ_LOAD, SEL_SECOND, i[6:0], i * 16 + 256, i << 20, 1'b0, '0, 1'b0);

    foreach (dir_rows[i])
      send_request(dir_rows[i].lim, dir_rows[i].sel, dir_rows[i].idx, dir_rows[i].en,
                   dir_rows[i].lim_in, dir_rows[i].typed, dir_rows[i].x_lim,
                   dir_rows[i].x_sat);

    for (int p = 0; p < PHASES; p++) begin
      // Configure only with the block idle and nothing outstanding.
      drain();
      write_reg(CFG_LAST_FIRST, phase_last[p][0]);
      write_reg(CFG_LAST_SECOND, phase_last[p][1]);
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE_A, CFG_W'($urandom));
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE_B, CFG_W'($urandom));
      no_idle = (p % 3 == 1);
      load_table(2'($urandom_range(0, 1)), p == 3 || p == 6);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        sl = 2'($urandom_range(0, 1));
        if (pick < 10) begin
          // Stray load: any selector, random entry and content.
          send_request(REQ_LOAD, 2'($urandom_range(0, 3)), 7'($urandom), $urandom,
                       $urandom, 1'b0, '0, 1'b0);
        end else if (pick < 18) begin
          send_request(REQ_QUERY, $urandom_range(0, 1) ? SEL_NONE : SEL_BAD, 7'($urandom),
                       $urandom, $urandom, 1'b0, '0, 1'b0);
        end else begin
          k = sl * DEPTH + $urandom_range(0, last_idx[sl]);
          case ($urandom_range(0, 6))
            0: en = bp_energy[k];
            1, 2: en = bp_energy[k] + $urandom_range(1, 4095);
            3: en = bp_energy[k] - 1;
            4: en = $urandom;
            5: en = '0;
            default: en = $urandom_range(0, 1) ? 32'hffffffff
                                               : bp_energy[sl*DEPTH+last_idx[sl]] + $urandom;
          endcase
          send_request(REQ_QUERY, sl, 7'($urandom), en, $urandom, 1'b0, '0, 1'b0);
        end
        // Now and then stop sending until the pipe is empty.
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    if (err_count == 0) begin
      $display("PASS piecewise_linear_table_interp_core");
    end else begin
      $display("FAIL piecewise_linear_table_interp_core");
    end
    $finish;
  end

endmodule
